>>> sv/peqc_pkg.sv
// shared types, constants and codes of the pointer event queue controller
package peqc_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam int PIX_X_W   = 11;
  localparam int PIX_Y_W   = 13;
  localparam int HGT_W     = 6;
  localparam int CELL_W    = 8;
  localparam int BTN_W     = 4;
  localparam int SHIFT_W   = 8;
  localparam int DEPTH_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int ENTRY_W   = BTN_W + 2 * CELL_W + SHIFT_W;

  // eight pixels per character column
  localparam int CELL_SHIFT  = 3;
  localparam int AREA_MARGIN = 2;

  // radix-16 restoring divider: four quotient bits per cycle
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_PAD_W     = 16;
  localparam int DIV_CYCLES    = DIV_PAD_W / DIV_STEP_BITS;

  localparam logic [DEPTH_W-1:0] HIDE_MAX = {DEPTH_W{1'b1}};

  localparam logic             ENABLE_RST      = 1'b1;
  localparam logic [HGT_W-1:0] CHAR_HEIGHT_RST = HGT_W'(16);
  localparam logic [CELL_W-1:0] COLUMNS_RST    = CELL_W'(80);
  localparam logic [CELL_W-1:0] ROWS_RST       = CELL_W'(25);

  typedef enum logic [2:0] {
    OP_REPORT    = 3'd0,
    OP_HIDE      = 3'd1,
    OP_SHOW      = 3'd2,
    OP_COND_HIDE = 3'd3,
    OP_GET       = 3'd4,
    OP_PREVIEW   = 3'd5,
    OP_CHECK     = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    KIND_ERASE = 3'd0,
    KIND_DRAW  = 3'd1,
    KIND_EVENT = 3'd2,
    KIND_FULL  = 3'd3,
    KIND_CHECK = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_CHAR_HEIGHT = 2'd1,
    CFG_COLUMNS     = 2'd2,
    CFG_TEXT_ROWS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic  load;
    logic  set_cell;
    logic  hide;
    logic  cursor_off;
    logic  arm_hit;
    logic  draw;
    logic  unhide;
    logic  set_area;
    logic  ring_write;
    logic  ring_pop;
    logic  emit;
    logic  last;
    kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic enable;
    logic moved;
    logic btn_any;
    logic shown;
    logic depth_zero;
    logic pending;
    logic in_cur_area;
    logic in_new_area;
    logic ring_empty;
    logic ring_full;
    logic show_draws;
    logic div_done;
  } dp_status_t;

endpackage

>>> sv/peqc_ram.sv
// generic single-write, single-read ram with registered read data
module peqc_ram #(
  parameter int WIDTH = peqc_pkg::ENTRY_W,
  parameter int DEPTH = peqc_pkg::RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/peqc_div.sv
// iterative restoring divider for the pixel row to character row conversion
module peqc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [peqc_pkg::PIX_Y_W-1:0]  dividend,
  input  logic [peqc_pkg::HGT_W-1:0]    divisor,
  output logic                          done,
  output logic [peqc_pkg::PIX_Y_W-1:0]  quotient
);

  import peqc_pkg::*;

  localparam int CNT_W = $clog2(DIV_CYCLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_PAD_W-1:0] num;
  logic [DIV_PAD_W-1:0] quo;
  logic [HGT_W-1:0]     rem;
  logic [HGT_W-1:0]     den;

  logic [DIV_PAD_W-1:0] num_next;
  logic [DIV_PAD_W-1:0] quo_next;
  logic [HGT_W-1:0]     rem_next;
  logic [HGT_W:0]       trial;

  // four compare-subtract steps on a 7-bit partial remainder
  always_comb begin
    rem_next = rem;
    num_next = num;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial    = {rem_next, num_next[DIV_PAD_W-1]};
      num_next = {num_next[DIV_PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next = HGT_W'(trial - {1'b0, den});
        quo_next = {quo_next[DIV_PAD_W-2:0], 1'b1};
      end else begin
        rem_next = trial[HGT_W-1:0];
        quo_next = {quo_next[DIV_PAD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= DIV_PAD_W'(dividend);
      quo <= '0;
      rem <= '0;
      den <= divisor;
    end else if (running) begin
      num <= num_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo[PIX_Y_W-1:0];

endmodule

>>> sv/peqc_dp.sv
// datapath: configuration, cursor and hide state, cell conversion, event ring, result registers
module peqc_dp #(
  parameter int RING_DEPTH = peqc_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  peqc_pkg::ctrl_cmd_t             cmd,
  output peqc_pkg::dp_status_t            stat,
  input  logic                            cfg_valid,
  input  logic [peqc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [peqc_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic [2:0]                      op,
  input  logic [peqc_pkg::PIX_X_W-1:0]    pixel_x,
  input  logic [peqc_pkg::PIX_Y_W-1:0]    pixel_y,
  input  logic                            moved,
  input  logic [peqc_pkg::BTN_W-1:0]      button_changes,
  input  logic [peqc_pkg::SHIFT_W-1:0]    key_shift_byte,
  input  logic [peqc_pkg::CELL_W-1:0]     area_left,
  input  logic [peqc_pkg::CELL_W-1:0]     area_top,
  input  logic [peqc_pkg::CELL_W-1:0]     area_right,
  input  logic [peqc_pkg::CELL_W-1:0]     area_bottom,
  output logic                            strobe,
  output logic [2:0]                      kind,
  output logic [peqc_pkg::CELL_W-1:0]     cell_x,
  output logic [peqc_pkg::CELL_W-1:0]     cell_y,
  output logic [peqc_pkg::BTN_W-1:0]      buttons,
  output logic [peqc_pkg::SHIFT_W-1:0]    shift_byte,
  output logic                            queue_not_empty,
  output logic                            last
);

  import peqc_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  // configuration
  logic              enable_r;
  logic [HGT_W-1:0]  char_height;
  logic [CELL_W-1:0] columns;
  logic [CELL_W-1:0] text_rows;

  // item latched at accept
  logic [2:0]         op_r;
  logic [CELL_W-1:0]  col_raw;
  logic               moved_r;
  logic [BTN_W-1:0]   btn_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [CELL_W-1:0]  req_left;
  logic [CELL_W-1:0]  req_top;
  logic [CELL_W-1:0]  req_right;
  logic [CELL_W-1:0]  req_bottom;

  // cursor and hide state
  logic [DEPTH_W-1:0] hide_depth;
  logic               hide_pending;
  logic [CELL_W-1:0]  hide_left;
  logic [CELL_W-1:0]  hide_top;
  logic [CELL_W-1:0]  hide_right;
  logic [CELL_W-1:0]  hide_bottom;
  logic               cursor_shown;
  logic [CELL_W-1:0]  shown_x;
  logic [CELL_W-1:0]  shown_y;
  logic [CELL_W-1:0]  cur_x;
  logic [CELL_W-1:0]  cur_y;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;

  logic [HGT_W-1:0]   height_eff;
  logic               div_done;
  logic [PIX_Y_W-1:0] quo;
  logic [CELL_W-1:0]  last_col;
  logic [CELL_W-1:0]  last_row;
  logic [CELL_W-1:0]  col_clamp;
  logic [CELL_W-1:0]  row_clamp;
  logic [CELL_W-1:0]  new_left;
  logic [CELL_W-1:0]  new_top;
  logic [CELL_W:0]    right_sum;
  logic [CELL_W:0]    bottom_sum;
  logic [CELL_W-1:0]  new_right;
  logic [CELL_W-1:0]  new_bottom;
  logic               in_new;
  logic               in_cur;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr_next;
  logic               ring_empty;
  logic               ring_full;
  logic [ENTRY_W-1:0] ring_wdata;
  logic [ENTRY_W-1:0] ring_rdata;

  assign height_eff = (char_height == '0) ? HGT_W'(1) : char_height;

  peqc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (pixel_y),
    .divisor  (height_eff),
    .done     (div_done),
    .quotient (quo)
  );

  // a zero register value counts as one
  assign last_col  = ((columns == '0) ? CELL_W'(1) : columns) - 1'b1;
  assign last_row  = ((text_rows == '0) ? CELL_W'(1) : text_rows) - 1'b1;
  assign col_clamp = (col_raw > last_col) ? last_col : col_raw;
  assign row_clamp = (quo > PIX_Y_W'(last_row)) ? last_row : quo[CELL_W-1:0];

  // requested rectangle widened by the margin, clipped to the cell range
  assign new_left   = (req_left >= CELL_W'(AREA_MARGIN)) ?
                      req_left - CELL_W'(AREA_MARGIN) : '0;
  assign new_top    = (req_top >= CELL_W'(AREA_MARGIN)) ?
                      req_top - CELL_W'(AREA_MARGIN) : '0;
  assign right_sum  = {1'b0, req_right} + (CELL_W + 1)'(AREA_MARGIN);
  assign bottom_sum = {1'b0, req_bottom} + (CELL_W + 1)'(AREA_MARGIN);
  assign new_right  = right_sum[CELL_W] ? {CELL_W{1'b1}} : right_sum[CELL_W-1:0];
  assign new_bottom = bottom_sum[CELL_W] ? {CELL_W{1'b1}} : bottom_sum[CELL_W-1:0];

  assign in_new = (cur_x >= new_left) && (cur_y >= new_top) &&
                  (cur_x <= new_right) && (cur_y <= new_bottom);
  assign in_cur = (cur_x >= hide_left) && (cur_y >= hide_top) &&
                  (cur_x <= hide_right) && (cur_y <= hide_bottom);

  assign wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign ring_empty  = (wr_ptr == rd_ptr);
  assign ring_full   = (wr_ptr_next == rd_ptr);
  assign ring_wdata  = {shift_r, cur_y, cur_x, btn_r};

  peqc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.ring_write),
    .waddr (wr_ptr),
    .wdata (ring_wdata),
    .raddr (rd_ptr),
    .rdata (ring_rdata)
  );

  always_comb begin
    stat.op          = op_t'(op_r);
    stat.enable      = enable_r;
    stat.moved       = moved_r;
    stat.btn_any     = |btn_r;
    stat.shown       = cursor_shown;
    stat.depth_zero  = (hide_depth == '0);
    stat.pending     = hide_pending;
    stat.in_cur_area = in_cur;
    stat.in_new_area = in_new;
    stat.ring_empty  = ring_empty;
    stat.ring_full   = ring_full;
    stat.show_draws  = !hide_pending && (hide_depth == DEPTH_W'(1));
    stat.div_done    = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op;
      col_raw    <= pixel_x[PIX_X_W-1:CELL_SHIFT];
      moved_r    <= moved;
      btn_r      <= button_changes;
      shift_r    <= key_shift_byte;
      req_left   <= area_left;
      req_top    <= area_top;
      req_right  <= area_right;
      req_bottom <= area_bottom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_r     <= ENABLE_RST;
      char_height  <= CHAR_HEIGHT_RST;
      columns      <= COLUMNS_RST;
      text_rows    <= ROWS_RST;
      hide_depth   <= '0;
      hide_pending <= 1'b0;
      hide_left    <= '0;
      hide_top     <= '0;
      hide_right   <= '0;
      hide_bottom  <= '0;
      cursor_shown <= 1'b0;
      shown_x      <= '0;
      shown_y      <= '0;
      cur_x        <= '0;
      cur_y        <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      strobe       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:      enable_r    <= cfg_data[0];
          CFG_CHAR_HEIGHT: char_height <= cfg_data[HGT_W-1:0];
          CFG_COLUMNS:     columns     <= cfg_data;
          CFG_TEXT_ROWS:   text_rows   <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.set_cell) begin
        cur_x <= col_clamp;
        cur_y <= row_clamp;
      end

      if (cmd.hide) begin
        if (hide_depth != HIDE_MAX) begin
          hide_depth <= hide_depth + 1'b1;
        end
      end else if (cmd.arm_hit) begin
        hide_depth <= DEPTH_W'(1);
      end else if (cmd.unhide && !hide_pending && (hide_depth != '0)) begin
        hide_depth <= hide_depth - 1'b1;
      end

      // show during a pending conditional hide only drops the pending hide
      if (cmd.set_area) begin
        hide_pending <= !in_new;
      end else if (cmd.arm_hit || cmd.unhide) begin
        hide_pending <= 1'b0;
      end

      if (cmd.set_area) begin
        hide_left   <= new_left;
        hide_top    <= new_top;
        hide_right  <= new_right;
        hide_bottom <= new_bottom;
      end

      if (cmd.hide || cmd.cursor_off) begin
        cursor_shown <= 1'b0;
      end else if (cmd.draw) begin
        cursor_shown <= 1'b1;
        shown_x      <= cur_x;
        shown_y      <= cur_y;
      end

      if (cmd.ring_write) begin
        wr_ptr <= wr_ptr_next;
      end
      if (cmd.ring_pop) begin
        rd_ptr <= rd_ptr_next;
      end

      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind <= cmd.kind;
      last <= cmd.last;
      case (cmd.kind)
        KIND_ERASE: begin
          cell_x          <= shown_x;
          cell_y          <= shown_y;
          buttons         <= '0;
          shift_byte      <= '0;
          queue_not_empty <= 1'b0;
        end
        KIND_DRAW: begin
          cell_x          <= cur_x;
          cell_y          <= cur_y;
          buttons         <= '0;
          shift_byte      <= '0;
          queue_not_empty <= 1'b0;
        end
        KIND_EVENT: begin
          if (ring_empty) begin
            cell_x          <= cur_x;
            cell_y          <= cur_y;
            buttons         <= '0;
            shift_byte      <= shift_r;
            queue_not_empty <= 1'b0;
          end else begin
            buttons         <= ring_rdata[BTN_W-1:0];
            cell_x          <= ring_rdata[BTN_W +: CELL_W];
            cell_y          <= ring_rdata[BTN_W + CELL_W +: CELL_W];
            shift_byte      <= ring_rdata[BTN_W + 2 * CELL_W +: SHIFT_W];
            queue_not_empty <= 1'b1;
          end
        end
        KIND_FULL: begin
          cell_x          <= cur_x;
          cell_y          <= cur_y;
          buttons         <= btn_r;
          shift_byte      <= shift_r;
          queue_not_empty <= 1'b1;
        end
        KIND_CHECK: begin
          cell_x          <= '0;
          cell_y          <= '0;
          buttons         <= '0;
          shift_byte      <= '0;
          queue_not_empty <= !ring_empty;
        end
        default: begin
          cell_x          <= '0;
          cell_y          <= '0;
          buttons         <= '0;
          shift_byte      <= '0;
          queue_not_empty <= 1'b0;
        end
      endcase
    end
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ring_write |-> !ring_full)
    else $error("event written into a full ring");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.ring_pop |-> !ring_empty)
    else $error("event removed from an empty ring");

endmodule

>>> sv/peqc_ctrl.sv
// controller: sequences each item and issues commands to the datapath
module peqc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  peqc_pkg::dp_status_t  stat,
  output peqc_pkg::ctrl_cmd_t   cmd
);

  import peqc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_MOVE,
    S_DRAW,
    S_FULL,
    S_READ
  } state_t;

  state_t state;
  state_t state_next;
  logic   full_due;
  logic   full_due_next;
  logic   move_hit;
  logic   move_draw;
  logic   move_full;

  assign busy = (state != S_IDLE);

  // decisions taken once the new cell is known
  assign move_hit  = stat.moved && stat.depth_zero && stat.pending && stat.in_cur_area;
  assign move_draw = stat.moved && stat.depth_zero && !move_hit;
  assign move_full = stat.btn_any && stat.ring_full;

  always_comb begin
    state_next    = state;
    full_due_next = full_due;
    cmd           = '0;
    cmd.kind      = KIND_ERASE;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_IDLE;
        if (stat.op == OP_CHECK) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          cmd.kind = KIND_CHECK;
        end else if (stat.enable) begin
          case (stat.op)
            OP_REPORT: state_next = S_DIV;
            OP_HIDE: begin
              cmd.hide = 1'b1;
              if (stat.shown) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.kind = KIND_ERASE;
              end
            end
            OP_SHOW: begin
              cmd.unhide = 1'b1;
              if (stat.show_draws) begin
                cmd.draw = 1'b1;
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.kind = KIND_DRAW;
              end
            end
            OP_COND_HIDE: begin
              if (stat.depth_zero) begin
                cmd.set_area = 1'b1;
                // pointer already inside: hide at once
                if (stat.in_new_area) begin
                  cmd.hide = 1'b1;
                  if (stat.shown) begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    cmd.kind = KIND_ERASE;
                  end
                end
              end
            end
            OP_GET, OP_PREVIEW: begin
              if (stat.ring_empty) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.kind = KIND_EVENT;
              end else begin
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        cmd.emit     = 1'b1;
        cmd.last     = 1'b1;
        cmd.kind     = KIND_EVENT;
        cmd.ring_pop = (stat.op == OP_GET);
        state_next   = S_IDLE;
      end

      S_DIV: begin
        if (stat.div_done) begin
          cmd.set_cell = 1'b1;
          state_next   = S_MOVE;
        end
      end

      S_MOVE: begin
        cmd.arm_hit    = move_hit;
        cmd.ring_write = stat.btn_any && !stat.ring_full;
        if (stat.moved && stat.shown) begin
          cmd.cursor_off = 1'b1;
          cmd.emit       = 1'b1;
          cmd.last       = !move_draw && !move_full;
          cmd.kind       = KIND_ERASE;
        end
        full_due_next = move_full;
        if (move_draw) begin
          state_next = S_DRAW;
        end else if (move_full) begin
          state_next = S_FULL;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_DRAW: begin
        cmd.draw   = 1'b1;
        cmd.emit   = 1'b1;
        cmd.last   = !full_due;
        cmd.kind   = KIND_DRAW;
        state_next = full_due ? S_FULL : S_IDLE;
      end

      S_FULL: begin
        cmd.emit   = 1'b1;
        cmd.last   = 1'b1;
        cmd.kind   = KIND_FULL;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      full_due <= 1'b0;
    end else begin
      state    <= state_next;
      full_due <= full_due_next;
    end
  end

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cmd.emit)
    else $error("result issued while idle");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("final result not followed by idle");

  a_move_after_divide: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> ($past(state) == S_DIV) && $past(stat.div_done))
    else $error("cursor step entered without a finished division");

endmodule

>>> sv/pointer_event_queue_controller.sv
// top level of the pointer event queue controller
//
// An item is taken when start is high and busy is low; busy stays high until the
// item is finished. Results come out one per cycle on the result ports, each
// marked by strobe for a single cycle, with last on the final one; they cannot
// be held off, so the receiver must take every strobe. From accept to the next
// accept a report steps through decode, the radix-16 row divider (pixel_y /
// char_height, four quotient bits a cycle, the last divider state also loading
// the clamped cell), erase and queue, and idle, with a draw state and a queue
// full state added when needed. Get and preview on a non-empty queue also pass
// through a read state because of the registered ring read. A result shows on
// the ports the cycle after it is issued, while the next item may already be
// taken. The event ring needs no clearing after reset. Configuration writes are
// always accepted and must only happen while busy is low and no result is
// pending.
module pointer_event_queue_controller #(
  parameter int RING_DEPTH = peqc_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      op,
  input  logic [peqc_pkg::PIX_X_W-1:0]    pixel_x,
  input  logic [peqc_pkg::PIX_Y_W-1:0]    pixel_y,
  input  logic                            moved,
  input  logic [peqc_pkg::BTN_W-1:0]      button_changes,
  input  logic [peqc_pkg::SHIFT_W-1:0]    key_shift_byte,
  input  logic [peqc_pkg::CELL_W-1:0]     area_left,
  input  logic [peqc_pkg::CELL_W-1:0]     area_top,
  input  logic [peqc_pkg::CELL_W-1:0]     area_right,
  input  logic [peqc_pkg::CELL_W-1:0]     area_bottom,
  output logic                            strobe,
  output logic [2:0]                      kind,
  output logic [peqc_pkg::CELL_W-1:0]     cell_x,
  output logic [peqc_pkg::CELL_W-1:0]     cell_y,
  output logic [peqc_pkg::BTN_W-1:0]      buttons,
  output logic [peqc_pkg::SHIFT_W-1:0]    shift_byte,
  output logic                            queue_not_empty,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [peqc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [peqc_pkg::CFG_DAT_W-1:0]  cfg_data
);

  import peqc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  peqc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  peqc_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .op              (op),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .moved           (moved),
    .button_changes  (button_changes),
    .key_shift_byte  (key_shift_byte),
    .area_left       (area_left),
    .area_top        (area_top),
    .area_right      (area_right),
    .area_bottom     (area_bottom),
    .strobe          (strobe),
    .kind            (kind),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .buttons         (buttons),
    .shift_byte      (shift_byte),
    .queue_not_empty (queue_not_empty),
    .last            (last)
  );

endmodule

>>> tb/pointer_event_queue_controller_tb.sv
// self-checking testbench for the pointer event queue controller
`timescale 1ns / 1ps

module pointer_event_queue_controller_tb;
  import peqc_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 6;
  localparam int RING           = RING_DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 12;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [2:0]        OP_UNUSED = 3'd7;
  localparam logic [CELL_W-1:0] CELL_MAX  = '1;

  typedef enum logic [1:0] {
    STIM_ITEM,
    STIM_CONFIG,
    STIM_SETTLE
  } stim_what_t;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIX
  } burst_t;

  typedef struct packed {
    stim_what_t           what;
    logic                 tight;
    logic [2:0]           op;
    logic [PIX_X_W-1:0]   pixel_x;
    logic [PIX_Y_W-1:0]   pixel_y;
    logic                 moved;
    logic [BTN_W-1:0]     btn;
    logic [SHIFT_W-1:0]   shift;
    logic [CELL_W-1:0]    area_l;
    logic [CELL_W-1:0]    area_t;
    logic [CELL_W-1:0]    area_r;
    logic [CELL_W-1:0]    area_b;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;
  } stim_entry_t;

  typedef struct packed {
    kind_t              kind;
    logic [CELL_W-1:0]  x;
    logic [CELL_W-1:0]  y;
    logic [BTN_W-1:0]   btn;
    logic [SHIFT_W-1:0] shift;
    logic               qne;
    logic               last;
  } pointer_result_t;

  typedef struct packed {
    logic [CELL_W-1:0]  x;
    logic [CELL_W-1:0]  y;
    logic [BTN_W-1:0]   btn;
    logic [SHIFT_W-1:0] shift;
  } ring_entry_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        cfg_valid = 1'b0;
  stim_entry_t drv       = '0;

  wire                busy, strobe, cfg_ready, res_qne, res_last;
  wire [2:0]          res_kind;
  wire [CELL_W-1:0]   res_x, res_y;
  wire [BTN_W-1:0]    res_btn;
  wire [SHIFT_W-1:0]  res_shift;

  // handshake bookkeeping between monitor and driver
  logic item_taken  = 1'b0;
  logic cfg_taken   = 1'b0;
  logic busy_seen   = 1'b0;
  int   idle_cycles = 0;
  int   gap_left    = 0;
  int   quiet_left  = SETTLE_CYCLES;
  int   fails       = 0;

  stim_entry_t     stimulus_q[$];
  pointer_result_t step_out[$];
  pointer_result_t pointer_outputs_q[$];

  // predicted block state
  logic                dev_on;
  logic [HGT_W-1:0]    char_h;
  logic [CELL_W-1:0]   col_count, row_count;
  logic [DEPTH_W-1:0]  hide_cnt;
  logic                hide_armed, cur_on;
  logic [CELL_W-1:0]   zone_l, zone_t, zone_r, zone_b;
  logic [CELL_W-1:0]   drawn_x, drawn_y, pos_x, pos_y;
  ring_entry_t         event_store [RING];
  int                  wr_ptr, rd_ptr;

  always #HALF_PERIOD clk = ~clk;

  pointer_event_queue_controller i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (drv.op),
    .pixel_x        (drv.pixel_x),
    .pixel_y        (drv.pixel_y),
    .moved          (drv.moved),
    .button_changes (drv.btn),
    .key_shift_byte (drv.shift),
    .area_left      (drv.area_l),
    .area_top       (drv.area_t),
    .area_right     (drv.area_r),
    .area_bottom    (drv.area_b),
    .strobe         (strobe),
    .kind           (res_kind),
    .cell_x         (res_x),
    .cell_y         (res_y),
    .buttons        (res_btn),
    .shift_byte     (res_shift),
    .queue_not_empty(res_qne),
    .last           (res_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (drv.cfg_idx),
    .cfg_data       (drv.cfg_data)
  );

  function automatic void push_out(kind_t k, logic [CELL_W-1:0] x, logic [CELL_W-1:0] y,
                                   logic [BTN_W-1:0] b, logic [SHIFT_W-1:0] s, logic q);
    pointer_result_t r;
    r = '{kind: k, x: x, y: y, btn: b, shift: s, qne: q, last: 1'b0};
    step_out.push_back(r);
  endfunction

  function automatic logic in_zone(logic [CELL_W-1:0] x, logic [CELL_W-1:0] y);
    return x >= zone_l && y >= zone_t && x <= zone_r && y <= zone_b;
  endfunction

  function automatic void hide_cursor();
    if (hide_cnt != HIDE_MAX) hide_cnt = hide_cnt + 1'b1;
    if (cur_on) begin
      push_out(KIND_ERASE, drawn_x, drawn_y, '0, '0, 1'b0);
      cur_on = 1'b0;
    end
  endfunction

  function automatic void draw_cursor();
    drawn_x = pos_x;
    drawn_y = pos_y;
    cur_on  = 1'b1;
    push_out(KIND_DRAW, pos_x, pos_y, '0, '0, 1'b0);
  endfunction

  // works out the results of one accepted item and advances the predicted state
  function automatic void pointer_step(stim_entry_t it);
    logic [HGT_W-1:0]   hgt;
    logic [CELL_W-1:0]  lim_x, lim_y;
    logic [PIX_X_W-1:0] col_full;
    logic [PIX_Y_W-1:0] row_full;
    int                 wide_r, wide_b, nxt, i;
    logic               was_empty;
    pointer_result_t    r;
    was_empty = (wr_ptr == rd_ptr);
    step_out.delete();
    if (it.op == OP_CHECK) begin
      push_out(KIND_CHECK, '0, '0, '0, '0, !was_empty);
    end else if (dev_on) begin
      case (it.op)
        OP_REPORT: begin
          hgt      = (char_h == '0) ? HGT_W'(1) : char_h;
          lim_x    = (col_count == '0) ? '0 : col_count - 1'b1;
          lim_y    = (row_count == '0) ? '0 : row_count - 1'b1;
          col_full = it.pixel_x >> CELL_SHIFT;
          row_full = it.pixel_y / hgt;
          pos_x    = (col_full > lim_x) ? lim_x : col_full[CELL_W-1:0];
          pos_y    = (row_full > lim_y) ? lim_y : row_full[CELL_W-1:0];
          if (it.moved) begin
            if (cur_on) begin
              push_out(KIND_ERASE, drawn_x, drawn_y, '0, '0, 1'b0);
              cur_on = 1'b0;
            end
            // entering an armed area hides the cursor once
            if (hide_cnt == '0 && hide_armed && in_zone(pos_x, pos_y)) begin
              hide_cnt   = DEPTH_W'(1);
              hide_armed = 1'b0;
            end
            if (hide_cnt == '0) draw_cursor();
          end
          if (it.btn != '0) begin
            nxt = (wr_ptr + 1) % RING;
            if (nxt == rd_ptr) begin
              push_out(KIND_FULL, pos_x, pos_y, it.btn, it.shift, 1'b1);
            end else begin
              event_store[wr_ptr] = '{x: pos_x, y: pos_y, btn: it.btn, shift: it.shift};
              wr_ptr = nxt;
            end
          end
        end
        OP_HIDE: hide_cursor();
        OP_SHOW: begin
          if (hide_armed) begin
            hide_armed = 1'b0;
          end else if (hide_cnt != '0) begin
            hide_cnt = hide_cnt - 1'b1;
            if (hide_cnt == '0) draw_cursor();
          end
        end
        OP_COND_HIDE: begin
          if (hide_cnt == '0) begin
            zone_l = (it.area_l >= AREA_MARGIN) ? CELL_W'(it.area_l - AREA_MARGIN) : '0;
            zone_t = (it.area_t >= AREA_MARGIN) ? CELL_W'(it.area_t - AREA_MARGIN) : '0;
            wide_r = it.area_r + AREA_MARGIN;
            wide_b = it.area_b + AREA_MARGIN;
            zone_r = (wide_r > CELL_MAX) ? CELL_MAX : CELL_W'(wide_r);
            zone_b = (wide_b > CELL_MAX) ? CELL_MAX : CELL_W'(wide_b);
            hide_armed = 1'b1;
            if (in_zone(pos_x, pos_y)) begin
              hide_armed = 1'b0;
              hide_cursor();
            end
          end
        end
        OP_GET, OP_PREVIEW: begin
          if (!was_empty) begin
            push_out(KIND_EVENT, event_store[rd_ptr].x, event_store[rd_ptr].y,
                     event_store[rd_ptr].btn, event_store[rd_ptr].shift, 1'b1);
            if (it.op == OP_GET) rd_ptr = (rd_ptr + 1) % RING;
          end else begin
            push_out(KIND_EVENT, pos_x, pos_y, '0, it.shift, 1'b0);
          end
        end
        default: ;
      endcase
    end
    for (i = 0; i < step_out.size(); i++) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      pointer_outputs_q.push_back(r);
    end
  endfunction

  function automatic void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want_v, got_v);
      fails++;
    end
  endfunction

  // monitor: accepts items, config writes and results at the rising edge
  always @(posedge clk) begin : monitor
    pointer_result_t want;
    if (rst) begin
      dev_on     = ENABLE_RST;
      char_h     = CHAR_HEIGHT_RST;
      col_count  = COLUMNS_RST;
      row_count  = ROWS_RST;
      hide_cnt   = '0;
      hide_armed = 1'b0;
      cur_on     = 1'b0;
      {zone_l, zone_t, zone_r, zone_b} = '0;
      {drawn_x, drawn_y, pos_x, pos_y} = '0;
      wr_ptr     = 0;
      rd_ptr     = 0;
      pointer_outputs_q.delete();
      item_taken  <= 1'b0;
      cfg_taken   <= 1'b0;
      busy_seen   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      item_taken <= start && !busy;
      cfg_taken  <= cfg_valid && cfg_ready;
      busy_seen  <= busy;
      if (cfg_valid && cfg_ready) begin
        case (drv.cfg_idx)
          CFG_ENABLE:      dev_on    = drv.cfg_data[0];
          CFG_CHAR_HEIGHT: char_h    = drv.cfg_data[HGT_W-1:0];
          CFG_COLUMNS:     col_count = drv.cfg_data;
          CFG_TEXT_ROWS:   row_count = drv.cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) pointer_step(drv);
      if (strobe) begin
        if (pointer_outputs_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got kind %0d cell %0d,%0d btn %0h",
                   $time, res_kind, res_x, res_y, res_btn);
          fails++;
        end else begin
          want = pointer_outputs_q.pop_front();
          compare_field("kind", 16'(want.kind), 16'(res_kind));
          compare_field("cell_x", 16'(want.x), 16'(res_x));
          compare_field("cell_y", 16'(want.y), 16'(res_y));
          compare_field("buttons", 16'(want.btn), 16'(res_btn));
          compare_field("shift_byte", 16'(want.shift), 16'(res_shift));
          compare_field("queue_not_empty", 16'(want.qne), 16'(res_qne));
          compare_field("last", 16'(want.last), 16'(res_last));
        end
      end
      if ((start && !busy) || (cfg_valid && cfg_ready) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // driver: presents pending items and config writes at the falling edge
  always @(negedge clk) begin : driver
    logic        next_start, next_cfg;
    stim_entry_t head;
    int          roll;
    next_start = start;
    next_cfg   = cfg_valid;
    if (!rst) begin
      if (start && item_taken) next_start = 1'b0;
      if (cfg_valid && cfg_taken) next_cfg = 1'b0;
      if (!next_start && !next_cfg) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (stimulus_q.size() > 0) begin
          head = stimulus_q[0];
          case (head.what)
            STIM_ITEM: begin
              head = stimulus_q.pop_front();
              drv <= head;
              next_start = 1'b1;
              roll = $urandom_range(0, 99);
              if (head.tight || roll < 50) gap_left = 0;
              else if (roll < 90) gap_left = $urandom_range(1, 4);
              else gap_left = $urandom_range(10, 40);
            end
            STIM_CONFIG: begin
              head = stimulus_q.pop_front();
              drv <= head;
              next_cfg = 1'b1;
            end
            default: begin
              // hold off until every result is in and the block has gone quiet
              if (pointer_outputs_q.size() != 0 || busy_seen) begin
                quiet_left = SETTLE_CYCLES;
              end else if (quiet_left > 0) begin
                quiet_left = quiet_left - 1;
              end else begin
                head = stimulus_q.pop_front();
                quiet_left = SETTLE_CYCLES;
              end
            end
          endcase
        end
      end
    end
    start     <= next_start;
    cfg_valid <= next_cfg;
  end

  function automatic stim_entry_t settle_mark();
    stim_entry_t e;
    e = '0;
    e.what = STIM_SETTLE;
    return e;
  endfunction

  function automatic stim_entry_t cmd(logic [2:0] opc, logic [PIX_X_W-1:0] px,
                                      logic [PIX_Y_W-1:0] py, logic mv, logic [BTN_W-1:0] b,
                                      logic [SHIFT_W-1:0] sh, logic [CELL_W-1:0] l,
                                      logic [CELL_W-1:0] t, logic [CELL_W-1:0] r,
                                      logic [CELL_W-1:0] bt);
    stim_entry_t e;
    e = '0;
    e.what    = STIM_ITEM;
    e.op      = opc;
    e.pixel_x = px;
    e.pixel_y = py;
    e.moved   = mv;
    e.btn     = b;
    e.shift   = sh;
    e.area_l  = l;
    e.area_t  = t;
    e.area_r  = r;
    e.area_b  = bt;
    return e;
  endfunction

  function automatic stim_entry_t random_item(logic [2:0] opc, logic want_btn, logic tight);
    stim_entry_t e;
    int          lo;
    e = '0;
    e.what    = STIM_ITEM;
    e.op      = opc;
    e.tight   = tight;
    e.pixel_x = PIX_X_W'($urandom);
    e.pixel_y = $urandom_range(0, 1) ? PIX_Y_W'($urandom) : PIX_Y_W'($urandom_range(0, 511));
    e.moved   = 1'($urandom_range(0, 1));
    e.btn     = want_btn ? BTN_W'($urandom_range(1, 15)) : BTN_W'($urandom);
    e.shift   = SHIFT_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      {e.area_l, e.area_t, e.area_r, e.area_b} = $urandom;
    end else begin
      // small rectangles near the cursor's usual range
      lo = $urandom_range(0, 80);
      e.area_l = CELL_W'(lo);
      e.area_r = CELL_W'(lo + $urandom_range(0, 12));
      lo = $urandom_range(0, 40);
      e.area_t = CELL_W'(lo);
      e.area_b = CELL_W'(lo + $urandom_range(0, 8));
    end
    return e;
  endfunction

  task automatic add_config(logic [7:0] en, logic [7:0] hgt, logic [7:0] cols,
                            logic [7:0] rows);
    stim_entry_t e;
    stimulus_q.push_back(settle_mark());
    e = '0;
    e.what = STIM_CONFIG;
    e.cfg_idx = CFG_ENABLE;
    e.cfg_data = en;
    stimulus_q.push_back(e);
    e.cfg_idx = CFG_CHAR_HEIGHT;
    e.cfg_data = hgt;
    stimulus_q.push_back(e);
    e.cfg_idx = CFG_COLUMNS;
    e.cfg_data = cols;
    stimulus_q.push_back(e);
    e.cfg_idx = CFG_TEXT_ROWS;
    e.cfg_data = rows;
    stimulus_q.push_back(e);
  endtask

  // bursts of button reports fill the ring, bursts of reads drain it, mixed bursts draw on all ops
  task automatic add_random_phase(int count);
    int         made, len, k, roll;
    burst_t     mode;
    logic       tight;
    logic [2:0] opc;
    made = 0;
    mode = BURST_FILL;
    while (made < count) begin
      tight = ($urandom_range(0, 3) == 0);
      len = (mode == BURST_FILL) ? $urandom_range(14, 20) : $urandom_range(4, 12);
      if ($urandom_range(0, 5) == 0) stimulus_q.push_back(settle_mark());
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          BURST_FILL: opc = OP_REPORT;
          BURST_DRAIN: opc = (roll < 60) ? OP_GET : (roll < 80) ? OP_PREVIEW : OP_CHECK;
          default: begin
            if (roll < 40) opc = OP_REPORT;
            else if (roll < 50) opc = OP_HIDE;
            else if (roll < 63) opc = OP_SHOW;
            else if (roll < 78) opc = OP_COND_HIDE;
            else if (roll < 86) opc = OP_GET;
            else if (roll < 91) opc = OP_PREVIEW;
            else if (roll < 97) opc = OP_CHECK;
            else opc = OP_UNUSED;
          end
        endcase
        stimulus_q.push_back(random_item(opc, mode == BURST_FILL, tight));
      end
      made += len;
      mode = burst_t'($urandom_range(0, 2));
    end
  endtask

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("%0t watchdog: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : sequencer
    // directed part with the reset configuration
    stimulus_q.push_back(cmd(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_GET, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_PREVIEW, 0, 0, 0, 0, 8'h5A, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_REPORT, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_REPORT, 11'h7FF, 13'h1FFF, 1, 4'hF, 8'hA5, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_PREVIEW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_REPORT, 320, 192, 1, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_COND_HIDE, 0, 0, 0, 0, 0, 39, 11, 41, 13));
    stimulus_q.push_back(cmd(OP_COND_HIDE, 0, 0, 0, 0, 0, 0, 0, 255, 255));
    stimulus_q.push_back(cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_COND_HIDE, 0, 0, 0, 0, 0, 255, 255, 255, 255));
    stimulus_q.push_back(cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_COND_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_REPORT, 16, 32, 1, 4'hA, 8'hFF, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_UNUSED, 11'h7FF, 13'h1FFF, 1, 4'hF, 8'hFF, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_REPORT, 100, 100, 0, 4'h1, 0, 0, 0, 0, 0));
    stimulus_q.push_back(cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_random_phase(25);
    add_config(8'h01, 8'hE0, 8'hFF, 8'hFF);
    add_random_phase(25);
    add_config(8'h01, 8'h01, 8'h01, 8'h01);
    add_random_phase(25);
    // zero in a size register acts as one
    add_config(8'hFF, 8'hFF, 8'h00, 8'h00);
    add_random_phase(25);
    add_config(8'hFE, 8'(CHAR_HEIGHT_RST), COLUMNS_RST, ROWS_RST);
    add_random_phase(25);
    add_config(8'h01, 8'h00, 8'd132, 8'd60);
    add_random_phase(25);
    add_config(8'h01, 8'(CHAR_HEIGHT_RST), COLUMNS_RST, ROWS_RST);
    add_random_phase(25);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (stimulus_q.size() != 0 || start || cfg_valid) @(posedge clk);
    while (pointer_outputs_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
sv/peqc_pkg.sv
sv/peqc_ram.sv
sv/peqc_div.sv
sv/peqc_dp.sv
sv/peqc_ctrl.sv
sv/pointer_event_queue_controller.sv
tb/pointer_event_queue_controller_tb.sv
